// File: design/pve_pkg.sv
// Shared types, constants and classification function for the prefix varint encoder.
// No dependencies; imported by every module of the block.
package pve_pkg;

    localparam int ValW   = 64;
    localparam int ByteW  = 8;
    localparam int WordW  = ValW + ByteW;   // room for escape byte plus eight value bytes
    localparam int CntW   = 4;              // byte count 1..9
    localparam int MaxLen = 8;              // longest code without escape

    localparam logic [ByteW-1:0] EscByte = 8'hff;
    localparam logic [CntW-1:0]  EscCnt  = 4'd9;

    typedef struct packed {
        logic [WordW-1:0] word;   // code bytes, first byte in the top byte
        logic [CntW-1:0]  cnt;    // number of bytes in the code
    } t_entry;

    // Prefix run of n-1 ones at the top of the first byte.
    function automatic logic [ByteW-1:0] pve_prefix(input logic [CntW-1:0] n);
        logic [15:0] run;
        begin
            run = 16'hff00 >> (n - 4'd1);
            return run[ByteW-1:0];
        end
    endfunction

    // Classify a value: code length and left-aligned code bytes.
    function automatic t_entry pve_classify(input logic [ValW-1:0] v);
        t_entry           e;
        logic [CntW-1:0]  n;
        logic [6:0]       sh;
        logic [WordW-1:0] w;
        begin
            n = 4'd1;
            for (int k = 1; k < MaxLen; k++) begin
                if ((v >> (7 * k)) != '0) begin
                    n = CntW'(k + 1);
                end
            end
            if (v[ValW-1:56] != '0) begin
                e.word = {EscByte, v};
                e.cnt  = EscCnt;
            end else begin
                sh = 7'({3'd0, 4'd8 - n} << 3);
                w  = {v, {ByteW{1'b0}}} << sh;
                w[WordW-1 -: ByteW] = w[WordW-1 -: ByteW] | pve_prefix(n);
                e.word = w;
                e.cnt  = n;
            end
            return e;
        end
    endfunction

endpackage

// File: design/prefix_varint_encoder.sv
// Prefix varint encoder: 64-bit value in, prefix-coded byte stream out, first byte first.
// A value of length n gives n output bytes (1..8), a value of 2^56 or more gives nine:
// the serializer's output register sends one byte per cycle unless i_stall holds it.
// Input is taken every cycle while the two-entry queue between classifier and serializer
// has room, so a value is accepted while earlier codes are still being sent.
// When the block is empty, the first byte passes the queue, then the output register.
// Depends on pve_pkg, pve_front, pve_queue, pve_back.
module prefix_varint_encoder import pve_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [ValW-1:0]  i_value_in,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [ByteW-1:0] o_out_byte,
    output logic             o_last_byte
);

    logic   q_full, q_nonempty, push, pop;
    t_entry f_entry, q_entry;

    pve_front u_front (
        .i_valid    (i_valid),
        .i_value_in (i_value_in),
        .o_stall    (o_stall),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (f_entry)
    );

    pve_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (f_entry),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_entry    (q_entry)
    );

    pve_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_entry    (q_entry),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule

// File: design/pve_front.sv
// Front end: accepts input values and classifies them into code length and code bytes.
// Depends on pve_pkg.
module pve_front import pve_pkg::*; (
    input  logic            i_valid,
    input  logic [ValW-1:0] i_value_in,
    output logic            o_stall,
    input  logic            i_q_full,
    output logic            o_push,
    output t_entry          o_entry
);

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign o_entry = pve_classify(i_value_in);

endmodule

// File: design/pve_queue.sv
// Two-entry queue between the classifier and the byte serializer.
// Depends on pve_pkg.
module pve_queue import pve_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_nonempty,
    output t_entry o_entry
);

    t_entry     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_entry    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// File: design/pve_back.sv
// Back end: shifts the queued code out one byte per cycle, unless stalled, via an output register.
// Depends on pve_pkg.
module pve_back import pve_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_nonempty,
    input  t_entry           i_q_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [ByteW-1:0] o_out_byte,
    output logic             o_last_byte
);

    logic [WordW-1:0] r_word, n_word;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_ovalid, n_ovalid;
    logic [ByteW-1:0] r_obyte, n_obyte;
    logic             r_olast, n_olast;
    logic             load;

    // output slot free or its byte transfers this cycle
    assign load  = !r_ovalid || !i_stall;
    assign o_pop = load && (r_cnt == '0) && i_q_nonempty;

    always_comb begin
        n_word   = r_word;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        if (load) begin
            if (r_cnt != '0) begin
                n_obyte  = r_word[WordW-1 -: ByteW];
                n_olast  = (r_cnt == 4'd1);
                n_word   = r_word << ByteW;
                n_cnt    = r_cnt - 4'd1;
                n_ovalid = 1'b1;
            end else if (i_q_nonempty) begin
                n_obyte  = i_q_entry.word[WordW-1 -: ByteW];
                n_olast  = (i_q_entry.cnt == 4'd1);
                n_word   = i_q_entry.word << ByteW;
                n_cnt    = i_q_entry.cnt - 4'd1;
                n_ovalid = 1'b1;
            end else begin
                n_ovalid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_last_byte = r_olast;

endmodule

// File: design/pve_checker.sv
// Port-level checks for prefix_varint_encoder, bound to the top level.
// Depends on pve_pkg.
module pve_checker import pve_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [ByteW-1:0] o_out_byte,
    input logic             o_last_byte
);

    logic r_first;   // next output byte opens a new code

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (o_valid && !i_stall) begin
            r_first <= o_last_byte;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_last_byte))
        else $error("stalled output transfer changed");

    // a code's first byte has its top bit clear exactly when the code is one byte long
    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_first |-> (o_last_byte == !o_out_byte[ByteW-1]))
        else $error("first byte prefix does not match code length");

    // an empty block has room for a value
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_valid) && !$past(o_valid) && !o_valid |-> !o_stall)
        else $error("input stalled while block idle");

endmodule

bind prefix_varint_encoder pve_checker u_pve_checker (.*);

// File: tb/prefix_varint_encoder_tb.sv
// Self-checking testbench for prefix_varint_encoder: drives 64-bit values, predicts each
// prefix-coded byte sequence and checks every output byte and last flag in order.
// Depends on pve_pkg and the prefix_varint_encoder RTL.
`timescale 1ns / 100ps

module prefix_varint_encoder_tb import pve_pkg::*;;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
    } t_code_byte;

    // Expected byte stream of the encoder plus the comparison of each received byte.
    class varint_scoreboard;
        t_code_byte pending_bytes[$];
        int         errors;
        int         bytes_checked;
        int         length_hits[10];

        function new();
            errors = 0;
            bytes_checked = 0;
            foreach (length_hits[k]) length_hits[k] = 0;
        endfunction

        // Least n with v < 2^(7n); 9 means escape form.
        function int code_length(logic [ValW-1:0] v);
            for (int n = 1; n <= MaxLen; n++) begin
                if ((v >> (7 * n)) == '0) return n;
            end
            return 9;
        endfunction

        // Called on every accepted input transfer.
        function void note_value(logic [ValW-1:0] v);
            int               n;
            logic [15:0]      run;
            logic [ByteW-1:0] lead;
            t_code_byte       cb;
            n = code_length(v);
            length_hits[n]++;
            if (n == 9) begin
                cb.data = EscByte;
                cb.last = 1'b0;
                pending_bytes.push_back(cb);
                n = MaxLen;
                lead = '0;
            end else begin
                run  = 16'hff00 >> (n - 1);
                lead = run[ByteW-1:0];
            end
            for (int i = n - 1; i >= 0; i--) begin
                cb.data = v[8*i +: 8];
                if (i == n - 1) cb.data = cb.data | lead;
                cb.last = (i == 0);
                pending_bytes.push_back(cb);
            end
        endfunction

        // Called on every accepted output transfer.
        function void check_byte(logic [ByteW-1:0] data, logic last);
            t_code_byte want;
            bytes_checked++;
            if (pending_bytes.size() == 0) begin
                $display("%0t ERROR: unexpected byte, expected none, actual %02h last %0b",
                         $time, data, last);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (data !== want.data) begin
                $display("%0t ERROR: out_byte expected %02h actual %02h",
                         $time, want.data, data);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t ERROR: last_byte expected %0b actual %0b",
                         $time, want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [ValW-1:0]  i_value_in = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [ByteW-1:0] o_out_byte;
    logic             o_last_byte;

    varint_scoreboard sb;
    bit               tx_burst = 1'b0;
    bit               rx_burst = 1'b0;

    prefix_varint_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value_in  (i_value_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    always #1 i_clk = ~i_clk;

    // Offers one value after a random gap; returns at the edge of its transfer.
    task automatic send_value(input logic [ValW-1:0] v);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_value_in <= v;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        sb.note_value(v);
        if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
    endtask

    // Random value of code length at most n (1..8), mostly exactly n, or of the escape form for n = 9.
    function automatic logic [ValW-1:0] random_value(int n);
        logic [ValW-1:0] v;
        v = {$urandom, $urandom};
        if (n == 9) begin
            v[$urandom_range(56, 63)] = 1'b1;
        end else begin
            v = v & ((64'd1 << (7 * n)) - 64'd1);
            if ($urandom_range(0, 3) != 0) v[7 * n - 1] = 1'b1;
        end
        return v;
    endfunction

    // Output side: random stall before each byte, then take it.
    initial begin : byte_sink
        int               hold;
        logic [ByteW-1:0] data;
        logic             last;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = rx_burst ? 0 : $urandom_range(0, 13);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(negedge i_clk); while (!o_valid);
            data = o_out_byte;
            last = o_last_byte;
            @(posedge i_clk);
            sb.check_byte(data, last);
            if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
        end
    end

    initial begin : stimulus
        logic [ValW-1:0] edge_values[$];
        sb = new();
        edge_values = '{
            64'h0, 64'h1, 64'h7f, 64'h80, 64'h3fff, 64'h4000,
            64'h1f_ffff, 64'h20_0000, 64'hfff_ffff, 64'h1000_0000,
            64'h7_ffff_ffff, 64'h8_0000_0000, 64'h3ff_ffff_ffff, 64'h400_0000_0000,
            64'h1_ffff_ffff_ffff, 64'h2_0000_0000_0000,
            64'hff_ffff_ffff_ffff, 64'h100_0000_0000_0000,
            64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
            64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555
        };
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (edge_values[k]) send_value(edge_values[k]);
        repeat (158) send_value(random_value($urandom_range(1, 9)));
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Covered %0d values by code length 1..9: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.length_hits.sum() - sb.length_hits[0],
                 sb.length_hits[1], sb.length_hits[2], sb.length_hits[3],
                 sb.length_hits[4], sb.length_hits[5], sb.length_hits[6],
                 sb.length_hits[7], sb.length_hits[8], sb.length_hits[9]);
        $display("Checked %0d output bytes, %0d mismatches", sb.bytes_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS prefix_varint_encoder");
        end else begin
            $display("FAIL prefix_varint_encoder");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("Timeout with %0d bytes still expected", sb.pending());
        $display("FAIL prefix_varint_encoder");
        $finish;
    end

endmodule

// File: prefix_varint_encoder.f
design/pve_pkg.sv
design/pve_front.sv
design/pve_queue.sv
design/pve_back.sv
design/prefix_varint_encoder.sv
design/pve_checker.sv
tb/prefix_varint_encoder_tb.sv
